/* src/bounded_sequential_list_assert.svh */
// Assertion macros for the bounded sequential list; empty under synthesis.
`ifndef BOUNDED_SEQUENTIAL_LIST_ASSERT_SVH
`define BOUNDED_SEQUENTIAL_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_sequential_list: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_sequential_list: assertion failed");

`else

`define BSL_ASSERT_IMP(label, ante, cons)
`define BSL_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* src/bsl_pkg.sv */
// Types and constants shared by the bounded sequential list modules.
package bsl_pkg;

    // Default number of storage entries.
    localparam int DEPTH_DEF = 64;
    // Most result words a single dump may produce.
    localparam int MAX_RESULTS = 64;
    // Width of count, position and capacity.
    localparam int CNT_W = 7;
    // Width of a stored value.
    localparam int VAL_W = 32;
    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_SEARCH = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_DUMP   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT,
        S_DELETE,
        S_DUMP_RD,
        S_DUMP_WR,
        S_RESP
    } state_t;

    // One result word handed from the engine to the output register.
    typedef struct packed {
        logic                    valid;
        status_t                 status;
        logic signed [VAL_W-1:0] entry;
        logic                    last;
    } res_t;

endpackage

/* src/bsl_engine.sv */
// List engine: entry memory, count and the sequencer for all operations.
`include "bounded_sequential_list_assert.svh"

module bsl_engine
    import bsl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [2:0]              in_op,
    input  logic [CNT_W-1:0]        in_pos,
    input  logic signed [VAL_W-1:0] in_val,
    input  logic [CNT_W-1:0]        cap,
    input  logic                    out_free,
    output logic                    in_ready,
    output res_t                    res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CAP_MAX =
        CNT_W'((DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS);

    // Maps a list position onto a memory address.
    function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] idx);
        logic [AW+CNT_W-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    state_t                  state_reg,   state_next;
    logic [CNT_W-1:0]        count_reg,   count_next;
    logic [CNT_W-1:0]        j_reg,       j_next;
    logic [CNT_W-1:0]        wa_reg,      wa_next;
    logic                    pend_reg,    pend_next;
    status_t                 st_reg,      st_next;
    logic [CNT_W-1:0]        pos_reg,     pos_next;
    logic signed [VAL_W-1:0] val_reg,     val_next;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    logic [CNT_W-1:0]        cap_eff;

    assign cap_eff  = (cap > CAP_MAX) ? CAP_MAX : cap;
    assign in_ready = (state_reg == S_IDLE);

    // Entry memory with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Operand and walk registers.
    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        wa_reg  <= wa_next;
        st_reg  <= st_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
    end

    // Sequencer: next state, memory accesses and result words.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        st_next    = st_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        mem_re     = 1'b0;
        mem_raddr  = to_addr(j_reg);
        mem_we     = 1'b0;
        mem_waddr  = to_addr(wa_reg);
        mem_wdata  = rdata_reg;
        res        = '0;

        case (state_reg)
            S_IDLE:
            begin
                pend_next = 1'b0;
                if (in_valid)
                begin
                    pos_next = in_pos;
                    val_next = in_val;
                    case (op_t'(in_op))
                        OP_SEARCH:
                        begin
                            j_next     = '0;
                            state_next = S_SEARCH;
                        end
                        OP_INSERT:
                        begin
                            if (in_pos > count_reg)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_RESP;
                            end
                            else if (count_reg >= cap_eff)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                j_next     = count_reg;
                                state_next = S_INSERT;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else if (in_pos >= count_reg)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                j_next     = in_pos + 7'd1;
                                state_next = S_DELETE;
                            end
                        end
                        OP_DUMP:
                        begin
                            j_next = '0;
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            st_next    = ST_OK;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Compare each returned entry while the next read is in flight.
            S_SEARCH:
            begin
                if (pend_reg && (rdata_reg == val_reg))
                begin
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
                else if (j_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    j_next    = j_reg + 7'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_RESP;
                end
            end

            // Shift right from the tail down to the position, then store the value.
            S_INSERT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (j_reg > pos_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = to_addr(j_reg - 7'd1);
                    wa_next   = j_reg;
                    j_next    = j_reg - 7'd1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = to_addr(pos_reg);
                    mem_wdata  = val_reg;
                    count_next = count_reg + 7'd1;
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // Shift left from just after the position up to the tail.
            S_DELETE:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (j_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    wa_next   = j_reg - 7'd1;
                    j_next    = j_reg + 7'd1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - 7'd1;
                    st_next    = ST_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // Read one entry once the output register can take it.
            S_DUMP_RD:
            begin
                if (out_free)
                begin
                    mem_re     = 1'b1;
                    state_next = S_DUMP_WR;
                end
            end

            S_DUMP_WR:
            begin
                res.valid  = 1'b1;
                res.status = ST_OK;
                res.entry  = rdata_reg;
                res.last   = ((j_reg + 7'd1) == count_reg);
                j_next     = j_reg + 7'd1;
                state_next = res.last ? S_IDLE : S_DUMP_RD;
            end

            // Single status word for every other operation and for a dump of an empty list.
            S_RESP:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    res.status = st_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BSL_ASSERT_IMP(a_res_slot_free, res.valid, out_free)
    `BSL_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= CAP_MAX)
    `BSL_ASSERT_IMP(a_write_only_shift, mem_we, (state_reg == S_INSERT) || (state_reg == S_DELETE))
    `BSL_ASSERT_NXT(a_walk_keeps_count, (state_reg == S_SEARCH) || (state_reg == S_DUMP_RD) || (state_reg == S_DUMP_WR), $stable(count_reg))

endmodule

/* src/bounded_sequential_list.sv */
// Top level of the bounded sequential list: stream ports, capacity register, output word.
//
// An ordered list of signed 32-bit values with search, insert, delete, dump and
// clear, kept in a single-port-write memory with a registered read.
// One input word is taken at a time. Search walks the entries in order until
// it finds the value or reaches the tail, insert and delete shift the entries
// between the position and the tail one at a time, clear and refused operations
// answer with a status word alone, and dump reads each entry from memory and
// then places it in the output register. The memory takes one read and one
// write per cycle; a stalled output word adds its stall to the operation that
// is waiting to emit. A result word waits in the output register while the
// next input word is accepted. The list is empty after reset and needs no
// clearing pass; capacity resets to 64 and is limited to DEPTH and to 64.
module bounded_sequential_list
    import bsl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,  // capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,    // operation[2:0], position[9:3], value[41:10]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,    // status[2:0], entry[34:3]
    output logic              m_tlast
);

    logic [CNT_W-1:0]        cap_reg;
    logic                    m_tvalid_reg;
    status_t                 status_reg;
    logic signed [VAL_W-1:0] entry_reg;
    logic                    last_reg;
    logic                    out_free;
    res_t                    res;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    bsl_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tdata[2:0]),
        .in_pos   (s_tdata[9:3]),
        .in_val   (s_tdata[41:10]),
        .cap      (cap_reg),
        .out_free (out_free),
        .in_ready (s_tready),
        .res      (res)
    );

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
            entry_reg  <= res.entry;
            last_reg   <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, entry_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule

/* dv/tb_top.sv */
// Testbench for bounded_sequential_list: list operations checked against a predicted list.
module tb_top;
    import bsl_pkg::*;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int POS_MAX = (1 << CNT_W) - 1;
    // Cycles to let the block settle after the last expected word.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0]        position;
        logic [2:0]              operation;
    } list_cmd_t;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] entry;
        logic                    last;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tlast;

    // Commands waiting for the driver, and words the block still owes.
    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];

    // Predicted list contents and capacity register.
    logic signed [VAL_W-1:0] list_mem [DEPTH_DEF];
    int                      list_count = 0;
    logic [CNT_W-1:0]        list_cap = CAP_RESET;

    // Light view of the list used only to pick meaningful positions and values.
    logic signed [VAL_W-1:0] shadow_vals[$];
    int                      shadow_cap = DEPTH_DEF;

    int  mismatches = 0;
    logic in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  ready_mode = 0;
    int  ready_left = 0;
    bit  squeeze_go = 1'b0;
    bit  squeeze_done = 1'b0;
    int  squeeze_cnt = 0;
    int  quiet_cycles = 0;

    bounded_sequential_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // The capacity in force is limited by the storage depth and the dump length.
    function automatic int eff_capacity(input int cap);
        int c;
        c = cap;
        if (c > DEPTH_DEF) c = DEPTH_DEF;
        if (c > MAX_RESULTS) c = MAX_RESULTS;
        return c;
    endfunction

    function automatic void expect_word(input status_t st, input logic signed [VAL_W-1:0] ent,
                                        input logic lst);
        list_result_t r;
        r.status = st;
        r.entry  = ent;
        r.last   = lst;
        expected_results.push_back(r);
    endfunction

    // Applies one accepted command to the predicted list and queues its result words.
    function automatic void predict_list_op(input logic [2:0] op, input logic [CNT_W-1:0] pos,
                                            input logic signed [VAL_W-1:0] val);
        status_t st;
        int      j;
        case (op)
            OP_SEARCH:
            begin
                st = ST_NOT_FOUND;
                for (j = 0; j < list_count; j++)
                    if (list_mem[j] == val) st = ST_OK;
                expect_word(st, '0, 1'b1);
            end
            OP_INSERT:
            begin
                if (int'(pos) > list_count)
                    expect_word(ST_BAD_POS, '0, 1'b1);
                else if (list_count >= eff_capacity(int'(list_cap)))
                    expect_word(ST_FULL, '0, 1'b1);
                else
                begin
                    for (j = list_count; j > int'(pos); j--)
                        list_mem[j] = list_mem[j-1];
                    list_mem[pos] = val;
                    list_count++;
                    expect_word(ST_OK, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (list_count == 0)
                    expect_word(ST_EMPTY, '0, 1'b1);
                else if (int'(pos) >= list_count)
                    expect_word(ST_BAD_POS, '0, 1'b1);
                else
                begin
                    for (j = int'(pos) + 1; j < list_count; j++)
                        list_mem[j-1] = list_mem[j];
                    list_count--;
                    expect_word(ST_OK, '0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (list_count == 0)
                    expect_word(ST_EMPTY, '0, 1'b1);
                else
                    for (j = 0; j < list_count; j++)
                        expect_word(ST_OK, list_mem[j], j == list_count - 1);
            end
            OP_CLEAR:
            begin
                list_count = 0;
                expect_word(ST_OK, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("tb_top: mismatch: %s", msg);
        mismatches++;
    endtask

    // Capture config writes, check output words and predict accepted input words.
    always @(posedge clk)
    begin
        list_result_t exp_word;
        if (rst_n)
        begin
            if (cfg_we)
                list_cap = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected word status %0d entry %0d last %0b",
                                              m_tdata[2:0], $signed(m_tdata[34:3]), m_tlast));
                else
                begin
                    exp_word = expected_results.pop_front();
                    if (m_tdata[2:0] !== exp_word.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_tdata[2:0], exp_word.status.name()));
                    if (m_tdata[34:3] !== exp_word.entry)
                        report_mismatch($sformatf("entry %0d, expected %0d",
                                                  $signed(m_tdata[34:3]), exp_word.entry));
                    if (m_tlast !== exp_word.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, exp_word.last));
                end
            end
            if (s_tvalid && s_tready)
                predict_list_op(s_tdata[2:0], s_tdata[9:3], s_tdata[41:10]);
            in_taken <= s_tvalid && s_tready;
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Input driver: bursts of words separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                s_tdata  <= {6'd0, pending_cmds.pop_front()};
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output receiver: stall pattern that changes mode, plus one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (squeeze_go && !squeeze_done)
            begin
                squeeze_cnt++;
                if (squeeze_cnt >= HOLD_OFF_CYCLES)
                    squeeze_done = 1'b1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (ready_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    ready_left = $urandom_range(20, 150);
                end
                else
                    ready_left--;
                case (ready_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 5) != 0);
                    default: m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Queues one command and updates the generator's view of the list.
    function automatic void queue_cmd(input logic [2:0] op, input int pos,
                                      input logic signed [VAL_W-1:0] val);
        list_cmd_t c;
        c.operation = op;
        c.position  = pos[CNT_W-1:0];
        c.value     = val;
        pending_cmds.push_back(c);
        case (op)
            OP_INSERT:
                if (pos <= shadow_vals.size() && shadow_vals.size() < shadow_cap)
                    shadow_vals.insert(pos, val);
            OP_DELETE:
                if (pos < shadow_vals.size())
                    shadow_vals.delete(pos);
            OP_CLEAR:
                shadow_vals.delete();
            default: ;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(input int reuse_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return VAL_MIN;
        if (r < 10)
            return VAL_MAX;
        if (r < 10 + reuse_pct && shadow_vals.size() > 0)
            return shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
        return $urandom;
    endfunction

    // Mostly positions that the list accepts, with some anywhere in the field.
    function automatic int pick_position(input int limit);
        if (limit >= 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, limit);
        return $urandom_range(0, POS_MAX);
    endfunction

    task automatic run_random_phase(input int n_cmds, input int insert_pct);
        int r;
        for (int i = 0; i < n_cmds; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < insert_pct)
                queue_cmd(OP_INSERT, pick_position(shadow_vals.size()), pick_value(20));
            else if (r < insert_pct + 20)
                queue_cmd(OP_DELETE, pick_position(shadow_vals.size() - 1), $urandom);
            else if (r < insert_pct + 36)
                queue_cmd(OP_SEARCH, $urandom_range(0, POS_MAX), pick_value(60));
            else if (r < insert_pct + 44)
                queue_cmd(OP_DUMP, $urandom_range(0, POS_MAX), $urandom);
            else if (r < insert_pct + 47)
                queue_cmd(OP_CLEAR, $urandom_range(0, POS_MAX), $urandom);
            else if (r < insert_pct + 50)
                queue_cmd(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                          $urandom_range(0, POS_MAX), $urandom);
            else
                queue_cmd(OP_SEARCH, $urandom_range(0, POS_MAX), pick_value(60));
        end
    endtask

    // Waits until every word is sent and answered, then lets the block settle.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(input int cap);
        wait_idle();
        @(negedge clk);
        cfg_wdata <= cap[CNT_W-1:0];
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = eff_capacity(cap);
    endtask

    // Reset, stimulus phases and the final verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty list corner cases, extreme values and every operation.
        queue_cmd(OP_DUMP, 0, '0);
        queue_cmd(OP_DELETE, 0, '0);
        queue_cmd(OP_SEARCH, 0, '0);
        queue_cmd(OP_INSERT, 1, 32'sd7);
        queue_cmd(OP_INSERT, 0, VAL_MIN);
        queue_cmd(OP_INSERT, 1, VAL_MAX);
        queue_cmd(OP_INSERT, 1, -32'sd1);
        queue_cmd(OP_INSERT, 0, '0);
        queue_cmd(OP_INSERT, POS_MAX, 32'sd5);
        queue_cmd(OP_INSERT, DEPTH_DEF, 32'sd5);
        queue_cmd(OP_SEARCH, 0, -32'sd1);
        queue_cmd(OP_SEARCH, POS_MAX, VAL_MAX);
        queue_cmd(OP_SEARCH, 0, 32'sd12345);
        queue_cmd(OP_DELETE, 4, '0);
        queue_cmd(OP_DELETE, POS_MAX, '0);
        queue_cmd(OP_DELETE, 0, '0);
        queue_cmd(OP_DUMP, 0, '0);
        queue_cmd(OP_UNUSED_LO, $urandom_range(0, POS_MAX), $urandom);
        queue_cmd(OP_UNUSED_MID, $urandom_range(0, POS_MAX), $urandom);
        queue_cmd(OP_UNUSED_HI, $urandom_range(0, POS_MAX), $urandom);
        queue_cmd(OP_DELETE, 2, '0);
        queue_cmd(OP_SEARCH, 0, VAL_MIN);
        queue_cmd(OP_CLEAR, 0, '0);
        queue_cmd(OP_DUMP, 0, '0);

        // Small capacity: the full check, and the position check taking priority.
        set_capacity(2);
        queue_cmd(OP_INSERT, 0, $urandom);
        queue_cmd(OP_INSERT, 0, $urandom);
        queue_cmd(OP_INSERT, 0, $urandom);
        queue_cmd(OP_INSERT, 5, $urandom);
        queue_cmd(OP_DUMP, 0, '0);

        // Zero capacity: every insert is refused.
        set_capacity(0);
        queue_cmd(OP_INSERT, 0, $urandom);
        queue_cmd(OP_INSERT, 3, $urandom);
        queue_cmd(OP_CLEAR, 0, '0);
        queue_cmd(OP_INSERT, 0, $urandom);

        // Capacity above the depth saturates; fill the list while the receiver holds off.
        set_capacity(POS_MAX);
        squeeze_go = 1'b1;
        for (int i = 0; i < DEPTH_DEF; i++)
            queue_cmd(OP_INSERT, $urandom_range(0, shadow_vals.size()), pick_value(10));
        queue_cmd(OP_INSERT, 0, $urandom);
        queue_cmd(OP_DUMP, 0, '0);
        queue_cmd(OP_SEARCH, 0, pick_value(80));
        run_random_phase(50, 25);

        // Capacity lowered below the stored count.
        set_capacity(5);
        run_random_phase(40, 45);

        set_capacity(1);
        run_random_phase(40, 45);

        set_capacity(DEPTH_DEF);
        run_random_phase(60, 55);

        set_capacity($urandom_range(1, DEPTH_DEF));
        run_random_phase(40, 45);

        wait_idle();
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
